/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define TCGR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TCGR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hw/rtl/tcgr_pkg.sv */
package tcgr_pkg;

    // Screen and font limits
    localparam int MAX_COLUMNS = 512;
    localparam int MAX_ROWS    = 256;
    localparam int GLYPH_COUNT = 256;
    localparam int GLYPH_ROWS  = 16;
    localparam int GLYPH_WIDTH = 8;

    // Field widths
    localparam int CHAR_W     = 8;
    localparam int PIX_W      = 8;
    localparam int ADDR_W     = 48;
    localparam int PITCH_W    = 16;
    localparam int BPP_W      = 3;
    localparam int CFG_COLS_W = 10;
    localparam int CFG_ROWS_W = 9;
    localparam int FIDX_W     = 12;
    localparam int KIND_W     = 2;

    // Cursor widths; the _CALC widths also hold the limit itself
    localparam int COL_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_CALC_W = COL_W + 1;
    localparam int ROW_CALC_W = ROW_W + 1;

    // Font store geometry
    localparam int GLYPH_W    = $clog2(GLYPH_COUNT);
    localparam int GROW_W     = $clog2(GLYPH_ROWS);
    localparam int GCOL_W     = $clog2(GLYPH_WIDTH);
    localparam int FONT_AW    = GLYPH_W + GROW_W;
    localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_ROWS;

    // Address products
    localparam int PROW_W = ROW_W + GROW_W + PITCH_W;
    localparam int PCOL_W = COL_W + GCOL_W + BPP_W;

    // Stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ADDR_W;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRAPHICS_MODE   = 3'd5;

    // Register reset values
    localparam logic [CFG_COLS_W-1:0] RST_TEXT_COLUMNS    = 10'd80;
    localparam logic [CFG_ROWS_W-1:0] RST_TEXT_ROWS       = 9'd25;
    localparam logic [PITCH_W-1:0]    RST_LINE_PITCH      = 16'd2560;
    localparam logic [BPP_W-1:0]      RST_BYTES_PER_PIXEL = 3'd4;

    // Input opcodes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_FONT = 1'b1;

    // Special characters
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_GLYPH  = 2'd0,
        KIND_SCROLL = 2'd1,
        KIND_SERIAL = 2'd2
    } kind_t;

    // Address generator controls
    typedef struct packed {
        logic calc;
        logic load;
        logic step;
    } addr_ctl_t;

endpackage

/* hw/rtl/tcgr_ram.sv */
module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/tcgr_addr_gen.sv */
module tcgr_addr_gen (
    input  logic                                 aclk,
    input  tcgr_pkg::addr_ctl_t                  ctl,
    input  logic [tcgr_pkg::ROW_W-1:0]           draw_row,
    input  logic [tcgr_pkg::COL_W-1:0]           draw_col,
    input  logic [tcgr_pkg::PITCH_W-1:0]         line_pitch,
    input  logic [tcgr_pkg::BPP_W-1:0]           bytes_per_pixel,
    input  logic [tcgr_pkg::ADDR_W-1:0]          frame_base,
    output logic [tcgr_pkg::ADDR_W-1:0]          row_address
);

    logic [tcgr_pkg::PROW_W-1:0] prod_row_reg;
    logic [tcgr_pkg::PCOL_W-1:0] prod_col_reg;
    logic [tcgr_pkg::ADDR_W-1:0] addr_reg;

    logic [tcgr_pkg::ROW_W+tcgr_pkg::GROW_W-1:0] pix_line;
    logic [tcgr_pkg::COL_W+tcgr_pkg::GCOL_W-1:0] pix_col;

    // Pixel line and pixel column of the cell's top-left corner
    assign pix_line = {draw_row, {tcgr_pkg::GROW_W{1'b0}}};
    assign pix_col  = {draw_col, {tcgr_pkg::GCOL_W{1'b0}}};

    // Products first, then base sum, then one pitch per glyph row
    always_ff @(posedge aclk) begin
        if (ctl.calc) begin
            prod_row_reg <= tcgr_pkg::PROW_W'(pix_line) * tcgr_pkg::PROW_W'(line_pitch);
            prod_col_reg <= tcgr_pkg::PCOL_W'(pix_col) * tcgr_pkg::PCOL_W'(bytes_per_pixel);
        end
        if (ctl.load) begin
            addr_reg <= frame_base
                      + tcgr_pkg::ADDR_W'(prod_row_reg)
                      + tcgr_pkg::ADDR_W'(prod_col_reg);
        end else if (ctl.step) begin
            addr_reg <= addr_reg + tcgr_pkg::ADDR_W'(line_pitch);
        end
    end

    assign row_address = addr_reg;

endmodule

/* hw/rtl/text_console_glyph_renderer_core.sv */
// Text console glyph renderer. Input transfers carry either a font store byte
// (s_tuser = 1) or a character (s_tuser = 0); the 8x16 font lives in a
// 4096 x 8 synchronous RAM, and the cursor in registers. A printable character
// is accepted in ST_IDLE, then passes ST_CALC (address products), ST_BASE
// (base sum) and ST_ROWS, one glyph row per cycle while the output is not
// stalled, paced by the single font RAM read port; a scroll after it adds
// ST_SCROLL. Font writes, carriage returns, NUL and dropped characters stay in
// ST_IDLE, a serial byte in graphics mode adds ST_SERIAL, a scrolling line
// feed ST_SCROLL. The block takes one item at a time; stalls on m_tready hold
// it in ST_ROWS, ST_SCROLL or ST_SERIAL. The font RAM has no reset and no
// clearing pass: glyphs must be loaded before they are drawn. Configuration
// writes are taken every cycle and are meant only while the block is idle.
module text_console_glyph_renderer_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tcgr_pkg::S_TDATA_W-1:0]   s_tdata,  // char_code, font_index, font_bits
    input  logic [0:0]                       s_tuser,  // opcode
    input  logic                             s_tlast,  // end_of_write
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tcgr_pkg::M_TDATA_W-1:0]   m_tdata,  // row_address, pixel_bits, serial_byte
    output logic [tcgr_pkg::KIND_W-1:0]      m_tuser,  // kind
    output logic                             m_tlast,  // last
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CALC   = 6'b000010,
        ST_BASE   = 6'b000100,
        ST_ROWS   = 6'b001000,
        ST_SCROLL = 6'b010000,
        ST_SERIAL = 6'b100000
    } state_t;

    localparam logic [tcgr_pkg::GROW_W-1:0] LAST_ROW = tcgr_pkg::GROW_W'(tcgr_pkg::GLYPH_ROWS - 1);

    // Input fields
    logic                            s_opcode;
    logic [tcgr_pkg::CHAR_W-1:0]     s_char_code;
    logic                            s_end_of_write;
    logic [tcgr_pkg::FIDX_W-1:0]     s_font_index;
    logic [tcgr_pkg::PIX_W-1:0]      s_font_bits;
    logic                            s_accept;

    assign s_opcode       = s_tuser[0];
    assign s_end_of_write = s_tlast;
    assign s_char_code    = s_tdata[7:0];
    assign s_font_index   = s_tdata[19:8];
    assign s_font_bits    = s_tdata[27:20];
    assign s_accept       = s_tvalid && s_tready;

    // Configuration registers
    logic [tcgr_pkg::CFG_COLS_W-1:0] text_columns_reg;
    logic [tcgr_pkg::CFG_ROWS_W-1:0] text_rows_reg;
    logic [tcgr_pkg::PITCH_W-1:0]    line_pitch_reg;
    logic [tcgr_pkg::BPP_W-1:0]      bytes_per_pixel_reg;
    logic [tcgr_pkg::ADDR_W-1:0]     frame_base_reg;
    logic                            graphics_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_columns_reg    <= tcgr_pkg::RST_TEXT_COLUMNS;
            text_rows_reg       <= tcgr_pkg::RST_TEXT_ROWS;
            line_pitch_reg      <= tcgr_pkg::RST_LINE_PITCH;
            bytes_per_pixel_reg <= tcgr_pkg::RST_BYTES_PER_PIXEL;
            frame_base_reg      <= '0;
            graphics_mode_reg   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tcgr_pkg::REG_TEXT_COLUMNS:
                    text_columns_reg <= cfg_data[tcgr_pkg::CFG_COLS_W-1:0];
                tcgr_pkg::REG_TEXT_ROWS:
                    text_rows_reg <= cfg_data[tcgr_pkg::CFG_ROWS_W-1:0];
                tcgr_pkg::REG_LINE_PITCH:
                    line_pitch_reg <= cfg_data[tcgr_pkg::PITCH_W-1:0];
                tcgr_pkg::REG_BYTES_PER_PIXEL:
                    bytes_per_pixel_reg <= cfg_data[tcgr_pkg::BPP_W-1:0];
                tcgr_pkg::REG_FRAME_BASE:
                    frame_base_reg <= cfg_data[tcgr_pkg::ADDR_W-1:0];
                tcgr_pkg::REG_GRAPHICS_MODE:
                    graphics_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective screen size, clamped to the supported range
    logic [tcgr_pkg::COL_CALC_W-1:0] cols_eff;
    logic [tcgr_pkg::ROW_CALC_W-1:0] rows_eff;

    always_comb begin
        if (text_columns_reg == '0) begin
            cols_eff = tcgr_pkg::COL_CALC_W'(1);
        end else if (32'(text_columns_reg) > 32'(tcgr_pkg::MAX_COLUMNS)) begin
            cols_eff = tcgr_pkg::COL_CALC_W'(tcgr_pkg::MAX_COLUMNS);
        end else begin
            cols_eff = tcgr_pkg::COL_CALC_W'(text_columns_reg);
        end
        if (text_rows_reg == '0) begin
            rows_eff = tcgr_pkg::ROW_CALC_W'(1);
        end else if (32'(text_rows_reg) > 32'(tcgr_pkg::MAX_ROWS)) begin
            rows_eff = tcgr_pkg::ROW_CALC_W'(tcgr_pkg::MAX_ROWS);
        end else begin
            rows_eff = tcgr_pkg::ROW_CALC_W'(text_rows_reg);
        end
    end

    // Control and cursor state
    state_t                          state_reg, state_next;
    logic [tcgr_pkg::COL_W-1:0]      cursor_col_reg, cursor_col_next;
    logic [tcgr_pkg::ROW_W-1:0]      cursor_row_reg, cursor_row_next;
    logic                            skip_reg, skip_next;
    logic                            scroll_pend_reg, scroll_pend_next;
    logic [tcgr_pkg::GROW_W-1:0]     row_idx_reg, row_idx_next;
    logic [tcgr_pkg::GLYPH_W-1:0]    glyph_reg, glyph_next;
    logic [tcgr_pkg::COL_W-1:0]      draw_col_reg, draw_col_next;
    logic [tcgr_pkg::ROW_W-1:0]      draw_row_reg, draw_row_next;
    logic [tcgr_pkg::CHAR_W-1:0]     ser_reg, ser_next;

    // Output register
    logic                            m_tvalid_reg, m_tvalid_next;
    tcgr_pkg::kind_t                 out_kind_reg, out_kind_next;
    logic [tcgr_pkg::ADDR_W-1:0]     out_addr_reg, out_addr_next;
    logic [tcgr_pkg::PIX_W-1:0]      out_pix_reg, out_pix_next;
    logic [tcgr_pkg::CHAR_W-1:0]     out_ser_reg, out_ser_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // Delete steps back unless at column zero
    logic                            del_back;
    logic [tcgr_pkg::COL_W-1:0]      pr_draw_col;
    logic [tcgr_pkg::CHAR_W:0]       pr_char;
    logic [tcgr_pkg::GLYPH_W-1:0]    pr_glyph;

    assign del_back    = (s_char_code == tcgr_pkg::CH_DEL) && (cursor_col_reg != '0);
    assign pr_draw_col = del_back ? cursor_col_reg - 1'b1 : cursor_col_reg;
    assign pr_char     = {1'b0, (s_char_code == tcgr_pkg::CH_DEL) ? tcgr_pkg::CH_SPACE
                                                                  : s_char_code};
    // Character code modulo glyph count; the code is below twice the count
    assign pr_glyph = (32'(pr_char) >= 32'(tcgr_pkg::GLYPH_COUNT))
                    ? tcgr_pkg::GLYPH_W'(32'(pr_char) - 32'(tcgr_pkg::GLYPH_COUNT))
                    : tcgr_pkg::GLYPH_W'(pr_char);

    // Wrap and scroll check on the advanced cursor
    logic                            is_lf;
    logic [tcgr_pkg::COL_CALC_W-1:0] chk_col, chk_col_out;
    logic [tcgr_pkg::ROW_CALC_W-1:0] chk_row, chk_row_out;
    logic                            chk_scroll;

    assign is_lf = (s_char_code == tcgr_pkg::CH_LF);

    always_comb begin
        if (is_lf) begin
            chk_col = '0;
            chk_row = {1'b0, cursor_row_reg} + 1'b1;
        end else begin
            chk_col = {1'b0, pr_draw_col} + tcgr_pkg::COL_CALC_W'(!del_back);
            chk_row = {1'b0, cursor_row_reg};
        end
        chk_col_out = chk_col;
        chk_row_out = chk_row;
        if (chk_col_out >= cols_eff) begin
            chk_col_out = '0;
            chk_row_out = chk_row_out + 1'b1;
        end
        chk_scroll = (chk_row_out >= rows_eff);
        if (chk_scroll) begin
            chk_col_out = '0;
            chk_row_out = rows_eff - 1'b1;
        end
    end

    // Font store and address generator
    tcgr_pkg::addr_ctl_t             actl;
    logic                            font_we;
    logic [tcgr_pkg::FONT_AW-1:0]    font_raddr;
    logic [tcgr_pkg::PIX_W-1:0]      font_rdata;
    logic [tcgr_pkg::ADDR_W-1:0]     gen_addr;

    // Read the row that the next cycle shows, so stalls keep the data
    assign font_raddr = {glyph_reg, row_idx_next};

    tcgr_ram #(
        .WIDTH (tcgr_pkg::PIX_W),
        .DEPTH (tcgr_pkg::FONT_DEPTH)
    ) u_font_ram (
        .clk   (aclk),
        .we    (font_we),
        .waddr (s_font_index[tcgr_pkg::FONT_AW-1:0]),
        .wdata (s_font_bits),
        .raddr (font_raddr),
        .rdata (font_rdata)
    );

    tcgr_addr_gen u_addr_gen (
        .aclk            (aclk),
        .ctl             (actl),
        .draw_row        (draw_row_reg),
        .draw_col        (draw_col_reg),
        .line_pitch      (line_pitch_reg),
        .bytes_per_pixel (bytes_per_pixel_reg),
        .frame_base      (frame_base_reg),
        .row_address     (gen_addr)
    );

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        cursor_col_next  = cursor_col_reg;
        cursor_row_next  = cursor_row_reg;
        skip_next        = skip_reg;
        scroll_pend_next = scroll_pend_reg;
        row_idx_next     = row_idx_reg;
        glyph_next       = glyph_reg;
        draw_col_next    = draw_col_reg;
        draw_row_next    = draw_row_reg;
        ser_next         = ser_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        out_kind_next    = out_kind_reg;
        out_addr_next    = out_addr_reg;
        out_pix_next     = out_pix_reg;
        out_ser_next     = out_ser_reg;
        out_last_next    = out_last_reg;
        font_we          = 1'b0;
        actl             = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    priority if (s_opcode == tcgr_pkg::OP_FONT) begin
                        font_we = (32'(s_font_index) < 32'(tcgr_pkg::FONT_DEPTH));
                    end else if (skip_reg) begin
                        if (s_end_of_write) begin
                            skip_next = 1'b0;
                        end
                    end else if (s_char_code == tcgr_pkg::CH_NUL) begin
                        skip_next = !s_end_of_write;
                    end else if (graphics_mode_reg) begin
                        ser_next   = s_char_code;
                        state_next = ST_SERIAL;
                    end else if (s_char_code == tcgr_pkg::CH_CR) begin
                        cursor_col_next = '0;
                    end else if (is_lf) begin
                        cursor_col_next = chk_col_out[tcgr_pkg::COL_W-1:0];
                        cursor_row_next = chk_row_out[tcgr_pkg::ROW_W-1:0];
                        if (chk_scroll) begin
                            state_next = ST_SCROLL;
                        end
                    end else begin
                        draw_col_next    = pr_draw_col;
                        draw_row_next    = cursor_row_reg;
                        glyph_next       = pr_glyph;
                        scroll_pend_next = chk_scroll;
                        cursor_col_next  = chk_col_out[tcgr_pkg::COL_W-1:0];
                        cursor_row_next  = chk_row_out[tcgr_pkg::ROW_W-1:0];
                        state_next       = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                actl.calc  = 1'b1;
                state_next = ST_BASE;
            end
            ST_BASE: begin
                actl.load    = 1'b1;
                row_idx_next = '0;
                state_next   = ST_ROWS;
            end
            ST_ROWS: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    out_kind_next = tcgr_pkg::KIND_GLYPH;
                    out_addr_next = gen_addr;
                    out_pix_next  = font_rdata;
                    out_ser_next  = '0;
                    out_last_next = (row_idx_reg == LAST_ROW) && !scroll_pend_reg;
                    actl.step     = 1'b1;
                    row_idx_next  = row_idx_reg + 1'b1;
                    if (row_idx_reg == LAST_ROW) begin
                        state_next = scroll_pend_reg ? ST_SCROLL : ST_IDLE;
                    end
                end
            end
            ST_SCROLL: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    out_kind_next = tcgr_pkg::KIND_SCROLL;
                    out_addr_next = frame_base_reg;
                    out_pix_next  = '0;
                    out_ser_next  = '0;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SERIAL: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    out_kind_next = tcgr_pkg::KIND_SERIAL;
                    out_addr_next = '0;
                    out_pix_next  = '0;
                    out_ser_next  = ser_reg;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            skip_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            row_idx_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            skip_reg       <= skip_next;
            m_tvalid_reg   <= m_tvalid_next;
            row_idx_reg    <= row_idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        scroll_pend_reg <= scroll_pend_next;
        glyph_reg       <= glyph_next;
        draw_col_reg    <= draw_col_next;
        draw_row_reg    <= draw_row_next;
        ser_reg         <= ser_next;
        out_kind_reg    <= out_kind_next;
        out_addr_reg    <= out_addr_next;
        out_pix_reg     <= out_pix_next;
        out_ser_reg     <= out_ser_next;
        out_last_reg    <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_ser_reg, out_pix_reg, out_addr_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* hw/rtl/tcgr_checker.sv */
`include "assert_macros.svh"

module tcgr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tcgr_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [tcgr_pkg::KIND_W-1:0]      m_tuser,
    input logic                             m_tlast
);

    // A stalled result holds
    `TCGR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // No new character is taken while a glyph run is still being delivered
    `TCGR_ASSERT(a_no_accept_mid_run, m_tvalid && !m_tlast |-> !s_tready, "input taken mid run")

    // Scroll and serial results are always the final one of their item
    `TCGR_ASSERT(a_single_last, m_tvalid && (m_tuser == tcgr_pkg::KIND_SCROLL || m_tuser == tcgr_pkg::KIND_SERIAL) |-> m_tlast, "single result without last")

    // Only defined result kinds leave the block
    `TCGR_ASSERT(a_kind_valid, m_tvalid |-> (m_tuser == tcgr_pkg::KIND_GLYPH || m_tuser == tcgr_pkg::KIND_SCROLL || m_tuser == tcgr_pkg::KIND_SERIAL), "undefined result kind")

    // Reset empties the output
    `TCGR_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

bind text_console_glyph_renderer_core tcgr_checker u_tcgr_checker (.*);
